// ===== rtl/core/cfsg_pkg.sv =====
package cfsg_pkg;

    localparam int ITERATIONS = 16;

    localparam int CW = 52;
    localparam int ZW = 34;

    localparam int MUL_A_W   = 64;
    localparam int MUL_B_W   = 36;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    localparam int DIV_N_W   = 68;
    localparam int DIV_D_W   = 32;
    localparam int DIV_Q_W   = 16;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    localparam logic [31:0] CORDIC_GAIN_Q32 = 32'd2608131496;
    localparam logic [31:0] TWO_PI_Q29      = 32'd3373259426;
    localparam logic [35:0] TURN_RATE_Q48   = 36'd44798133900;

    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_PEER   = 2'd1;
    localparam logic [1:0] KIND_NOTE   = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic OUT_START = 1'b0;
    localparam logic OUT_TRACK = 1'b1;

    localparam logic [2:0] REG_RADIUS   = 3'd0;
    localparam logic [2:0] REG_ALTITUDE = 3'd1;
    localparam logic [2:0] REG_INIT_SPD = 3'd2;
    localparam logic [2:0] REG_GAIN     = 3'd3;
    localparam logic [2:0] REG_OWN_ID   = 3'd4;

    function automatic logic [31:0] atan_turn(input logic [4:0] k);
        logic [31:0] v;
        unique case (k)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000028;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000002;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000000;
            5'd31: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/cfsg_mul.sv =====
module cfsg_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [cfsg_pkg::MUL_A_W-1:0]      i_a,
    input  logic [cfsg_pkg::MUL_B_W-1:0]      i_b,
    output logic                              o_done,
    output logic [cfsg_pkg::MUL_P_W-1:0]      o_prod
);

    logic [cfsg_pkg::MUL_A_W-1:0]   r_a;
    logic [cfsg_pkg::MUL_B_W-1:0]   r_b;
    logic [cfsg_pkg::MUL_P_W-1:0]   r_acc;
    logic [cfsg_pkg::MUL_CNT_W-1:0] r_cnt;
    logic                           r_done;
    logic [cfsg_pkg::MUL_P_W-1:0]   addend;

    assign addend = r_b[cfsg_pkg::MUL_B_W-1]
                    ? {{cfsg_pkg::MUL_B_W{1'b0}}, r_a} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a   <= i_a;
                r_b   <= i_b;
                r_acc <= '0;
                r_cnt <= cfsg_pkg::MUL_CNT_W'(cfsg_pkg::MUL_B_W);
            end else if (r_cnt != '0) begin
                r_acc <= {r_acc[cfsg_pkg::MUL_P_W-2:0], 1'b0} + addend;
                r_b   <= {r_b[cfsg_pkg::MUL_B_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == cfsg_pkg::MUL_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== rtl/core/cfsg_div.sv =====
module cfsg_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [cfsg_pkg::DIV_N_W-1:0] i_num,
    input  logic [cfsg_pkg::DIV_D_W-1:0] i_den,
    output logic                         o_done,
    output logic [cfsg_pkg::DIV_Q_W-1:0] o_quo
);

    logic [cfsg_pkg::DIV_N_W-1:0]   r_num;
    logic [cfsg_pkg::DIV_D_W-1:0]   r_den;
    logic [cfsg_pkg::DIV_D_W-1:0]   r_rem;
    logic [cfsg_pkg::DIV_Q_W-1:0]   r_quo;
    logic [cfsg_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_done;
    logic [cfsg_pkg::DIV_D_W:0]     trial;
    logic [cfsg_pkg::DIV_D_W:0]     diff;
    logic                           ge;

    assign trial = {r_rem, r_num[cfsg_pkg::DIV_N_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num <= i_num;
                r_den <= i_den;
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= cfsg_pkg::DIV_CNT_W'(cfsg_pkg::DIV_N_W);
            end else if (r_cnt != '0) begin
                r_rem <= ge ? diff[cfsg_pkg::DIV_D_W-1:0] : trial[cfsg_pkg::DIV_D_W-1:0];
                r_quo <= {r_quo[cfsg_pkg::DIV_Q_W-2:0], ge};
                r_num <= {r_num[cfsg_pkg::DIV_N_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == cfsg_pkg::DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/core/cfsg_cordic.sv =====
module cfsg_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_vector,
    input  logic [15:0]        i_phase,
    input  logic [47:0]        i_xmag,
    input  logic signed [31:0] i_px,
    input  logic signed [31:0] i_py,
    output logic               o_done,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y,
    output logic [15:0]        o_theta
);

    localparam logic signed [cfsg_pkg::ZW-1:0] Z_QTR  = cfsg_pkg::ZW'(34'sh0_4000_0000);
    localparam logic signed [cfsg_pkg::ZW-1:0] Z_HALF = cfsg_pkg::ZW'(34'sh0_8000_0000);
    localparam logic [4:0] LAST = 5'(cfsg_pkg::ITERATIONS - 1);

    logic signed [cfsg_pkg::CW-1:0] r_x, r_y;
    logic signed [cfsg_pkg::ZW-1:0] r_z;
    logic [4:0]                     r_i;
    logic                           r_mode, r_busy, r_done, r_origin;

    logic signed [cfsg_pkg::CW-1:0] x0, y0, vx, vy, dx, dy;
    logic signed [cfsg_pkg::ZW-1:0] z0, zp, ang;
    logic signed [cfsg_pkg::CW:0]   xr, yr;
    logic signed [cfsg_pkg::ZW-1:0] zr;
    logic                           s;

    function automatic logic [31:0] sat32(input logic [cfsg_pkg::CW-16:0] v);
        logic [31:0] r;
        if ((&v[cfsg_pkg::CW-16:31]) || !(|v[cfsg_pkg::CW-16:31])) begin
            r = v[31:0];
        end else begin
            r = v[cfsg_pkg::CW-16] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    always_comb begin
        vx = {{(cfsg_pkg::CW-48){i_px[31]}}, i_px, 16'h0};
        vy = {{(cfsg_pkg::CW-48){i_py[31]}}, i_py, 16'h0};
        zp = {{(cfsg_pkg::ZW-32){i_phase[15]}}, i_phase, 16'h0};
        x0 = {{(cfsg_pkg::CW-48){1'b0}}, i_xmag};
        y0 = '0;
        z0 = zp;
        if (i_vector) begin
            x0 = vx;
            y0 = vy;
            z0 = '0;
            if (i_px[31]) begin
                z0 = i_py[31] ? -Z_HALF : Z_HALF;
                x0 = -vx;
                y0 = -vy;
            end
        end else if (zp > Z_QTR) begin
            z0 = zp - Z_HALF;
            x0 = -x0;
        end else if (zp < -Z_QTR) begin
            z0 = zp + Z_HALF;
            x0 = -x0;
        end
    end

    assign dx  = r_y >>> r_i;
    assign dy  = r_x >>> r_i;
    assign ang = {{(cfsg_pkg::ZW-32){1'b0}}, cfsg_pkg::atan_turn(r_i)};
    assign s   = r_mode ? !r_y[cfsg_pkg::CW-1] : r_z[cfsg_pkg::ZW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x      <= x0;
                r_y      <= y0;
                r_z      <= z0;
                r_i      <= '0;
                r_mode   <= i_vector;
                r_origin <= i_vector && (i_px == '0) && (i_py == '0);
                r_busy   <= 1'b1;
            end else if (r_busy) begin
                if (s) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + ang;
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - ang;
                end
                r_i <= r_i + 1'b1;
                if (r_i == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign xr = {r_x[cfsg_pkg::CW-1], r_x} + (cfsg_pkg::CW+1)'(32768);
    assign yr = {r_y[cfsg_pkg::CW-1], r_y} + (cfsg_pkg::CW+1)'(32768);
    assign zr = r_z + cfsg_pkg::ZW'(32768);

    assign o_done  = r_done;
    assign o_x     = sat32(xr[cfsg_pkg::CW:16]);
    assign o_y     = sat32(yr[cfsg_pkg::CW:16]);
    assign o_theta = r_origin ? 16'h0 : zr[31:16];

endmodule

// ===== rtl/core/circle_formation_setpoint_generator.sv =====
// Circle-formation setpoint generator. Items are taken one at a time: o_in_stall is high from
// acceptance until the item's work is done, while a finished result may still wait in the
// output register. Ignored items (unused kind, zero total, repeated notification, tick before
// start, NaN peer angle) leave the input unstalled. A peer angle stalls the input for two
// 36-step bit-serial products. A notification stalls it for a 68-step restoring divide, one
// product for the scaled radius and one CORDIC pass. A tick stalls it for a vectoring CORDIC
// pass, two products and a divide for the phase advance (skipped with a zero radius), then
// the radius product and a rotating CORDIC pass. A result that finds the output register
// still held waits in S_EMIT, and the input stays stalled. The serial multiplier, the
// divider and the CORDIC are shared and used one after another.
module circle_formation_setpoint_generator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  logic [31:0]        i_elapsed_ms,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [15:0] i_peer_theta,
    input  logic               i_peer_theta_nan,
    input  logic [7:0]         i_vehicle_index,
    input  logic [7:0]         i_vehicle_total,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_out_kind,
    output logic signed [31:0] o_set_x,
    output logic signed [31:0] o_set_y,
    output logic signed [31:0] o_set_z,
    output logic [15:0]        o_set_yaw,
    output logic signed [15:0] o_measured_theta,
    output logic [7:0]         o_sender_id,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_NOTE = 11'b000_0000_0010,
        S_SPD1 = 11'b000_0000_0100,
        S_SPD2 = 11'b000_0000_1000,
        S_ANG  = 11'b000_0001_0000,
        S_ADV1 = 11'b000_0010_0000,
        S_ADV2 = 11'b000_0100_0000,
        S_ADVD = 11'b000_1000_0000,
        S_RAD  = 11'b001_0000_0000,
        S_ROT  = 11'b010_0000_0000,
        S_EMIT = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_launch;

    logic [31:0] r_radius, r_altitude, r_init_speed, r_gain;
    logic [7:0]  r_own_id;
    logic [31:0] r_speed;
    logic [15:0] r_start_phase, r_set_phase;
    logic        r_started;

    logic [31:0] r_elapsed;
    logic [31:0] r_px, r_py;
    logic [7:0]  r_idx, r_total;
    logic [16:0] r_mag;
    logic        r_neg, r_tick;
    logic [15:0] r_meas;

    logic        r_out_valid, r_o_kind;
    logic [31:0] r_o_x, r_o_y, r_o_z;
    logic [15:0] r_o_yaw, r_o_meas;
    logic [7:0]  r_o_id;

    logic        in_acc, cfg_wr, out_free;
    logic [17:0] diff, ndiff;
    logic [16:0] mag;
    logic [31:0] spd_mag;
    logic [27:0] step;
    logic [33:0] spd_sum;
    logic [31:0] spd_sat;
    logic [15:0] adv;

    logic                            mul_start, mul_done;
    logic [cfsg_pkg::MUL_A_W-1:0]    mul_a;
    logic [cfsg_pkg::MUL_B_W-1:0]    mul_b;
    logic [cfsg_pkg::MUL_P_W-1:0]    mul_prod;
    logic                            div_start, div_done;
    logic [cfsg_pkg::DIV_N_W-1:0]    div_num;
    logic [cfsg_pkg::DIV_D_W-1:0]    div_den;
    logic [cfsg_pkg::DIV_Q_W-1:0]    div_quo;
    logic                            cor_start, cor_done;
    logic signed [31:0]              cor_x, cor_y;
    logic [15:0]                     cor_theta;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign cfg_wr   = psel && penable && pwrite;
    assign out_free = !r_out_valid || !i_out_stall;

    assign diff    = {2'b00, r_set_phase} - {{2{i_peer_theta[15]}}, i_peer_theta};
    assign ndiff   = -diff;
    assign mag     = diff[17] ? ndiff[16:0] : diff[16:0];
    assign spd_mag = r_speed[31] ? -r_speed : r_speed;
    assign step    = mul_prod[80:53];
    assign spd_sum = r_neg ? ({{2{r_speed[31]}}, r_speed} - {6'b0, step})
                           : ({{2{r_speed[31]}}, r_speed} + {6'b0, step});
    assign spd_sat = ((spd_sum[33:31] == 3'b000) || (spd_sum[33:31] == 3'b111))
                     ? spd_sum[31:0]
                     : (spd_sum[33] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    assign adv     = r_speed[31] ? -div_quo : div_quo;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_kind)
                        cfsg_pkg::KIND_NOTE:
                            if (i_vehicle_total != 8'd0 && !r_started) n_state = S_NOTE;
                        cfsg_pkg::KIND_PEER: if (!i_peer_theta_nan) n_state = S_SPD1;
                        cfsg_pkg::KIND_TICK: if (r_started) n_state = S_ANG;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_NOTE: if (div_done) n_state = S_RAD;
            S_SPD1: if (mul_done) n_state = S_SPD2;
            S_SPD2: if (mul_done) n_state = S_IDLE;
            S_ANG:  if (cor_done) n_state = (r_radius == 32'd0) ? S_RAD : S_ADV1;
            S_ADV1: if (mul_done) n_state = S_ADV2;
            S_ADV2: if (mul_done) n_state = S_ADVD;
            S_ADVD: if (div_done) n_state = S_RAD;
            S_RAD:  if (mul_done) n_state = S_ROT;
            S_ROT:  if (cor_done) n_state = S_EMIT;
            S_EMIT: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign mul_start = r_launch && (r_state == S_SPD1 || r_state == S_SPD2 ||
                       r_state == S_ADV1 || r_state == S_ADV2 || r_state == S_RAD);
    assign div_start = r_launch && (r_state == S_NOTE || r_state == S_ADVD);
    assign cor_start = r_launch && (r_state == S_ANG || r_state == S_ROT);

    always_comb begin
        unique case (r_state)
            S_SPD1: begin
                mul_a = {32'b0, r_gain};
                mul_b = {19'b0, r_mag};
            end
            S_SPD2: begin
                mul_a = {15'b0, mul_prod[48:0]};
                mul_b = {4'b0, cfsg_pkg::TWO_PI_Q29};
            end
            S_ADV1: begin
                mul_a = {32'b0, r_elapsed};
                mul_b = {4'b0, spd_mag};
            end
            S_ADV2: begin
                mul_a = mul_prod[63:0];
                mul_b = cfsg_pkg::TURN_RATE_Q48;
            end
            default: begin
                mul_a = {32'b0, r_radius};
                mul_b = {4'b0, cfsg_pkg::CORDIC_GAIN_Q32};
            end
        endcase
    end

    assign div_num = (r_state == S_NOTE) ? {44'b0, r_idx, 16'h0} : mul_prod[99:32];
    assign div_den = (r_state == S_NOTE) ? {24'b0, r_total} : r_radius;

    cfsg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    cfsg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    cfsg_cordic u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (cor_start),
        .i_vector (r_state == S_ANG),
        .i_phase  (r_set_phase),
        .i_xmag   (mul_prod[63:16]),
        .i_px     (r_px),
        .i_py     (r_py),
        .o_done   (cor_done),
        .o_x      (cor_x),
        .o_y      (cor_y),
        .o_theta  (cor_theta)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_launch      <= 1'b0;
            r_radius      <= 32'd65536;
            r_altitude    <= 32'd65536;
            r_init_speed  <= 32'd0;
            r_gain        <= 32'd16777;
            r_own_id      <= 8'd0;
            r_speed       <= 32'd0;
            r_start_phase <= 16'd0;
            r_set_phase   <= 16'd0;
            r_started     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= (n_state != r_state);

            if (in_acc) begin
                r_elapsed <= i_elapsed_ms;
                r_px      <= i_pos_x;
                r_py      <= i_pos_y;
                r_idx     <= i_vehicle_index;
                r_total   <= i_vehicle_total;
                r_mag     <= mag;
                r_neg     <= diff[17];
                r_tick    <= (i_kind == cfsg_pkg::KIND_TICK);
            end

            if (r_state == S_NOTE && div_done) begin
                r_start_phase <= div_quo;
                r_set_phase   <= div_quo;
                r_started     <= 1'b1;
            end
            if (r_state == S_SPD2 && mul_done) begin
                r_speed <= spd_sat;
            end
            if (r_state == S_ANG && cor_done) begin
                r_meas <= cor_theta;
                if (r_radius == 32'd0) begin
                    r_set_phase <= r_start_phase;
                end
            end
            if (r_state == S_ADVD && div_done) begin
                r_set_phase <= r_start_phase + adv;
            end

            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
                r_o_kind    <= r_tick ? cfsg_pkg::OUT_TRACK : cfsg_pkg::OUT_START;
                r_o_x       <= cor_x;
                r_o_y       <= cor_y;
                r_o_z       <= r_altitude;
                r_o_yaw     <= r_set_phase;
                r_o_meas    <= r_tick ? r_meas : 16'h0;
                r_o_id      <= r_tick ? r_own_id : 8'h0;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_wr) begin
                unique case (paddr[4:2])
                    cfsg_pkg::REG_RADIUS:   r_radius   <= pwdata;
                    cfsg_pkg::REG_ALTITUDE: r_altitude <= pwdata;
                    cfsg_pkg::REG_INIT_SPD: begin
                        r_init_speed <= pwdata;
                        r_speed      <= pwdata;
                    end
                    cfsg_pkg::REG_GAIN:     r_gain     <= pwdata;
                    cfsg_pkg::REG_OWN_ID:   r_own_id   <= pwdata[7:0];
                    default:                r_own_id   <= r_own_id;
                endcase
            end
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            cfsg_pkg::REG_RADIUS:   prdata = r_radius;
            cfsg_pkg::REG_ALTITUDE: prdata = r_altitude;
            cfsg_pkg::REG_INIT_SPD: prdata = r_init_speed;
            cfsg_pkg::REG_GAIN:     prdata = r_gain;
            cfsg_pkg::REG_OWN_ID:   prdata = {24'h0, r_own_id};
            default:                prdata = 32'h0;
        endcase
    end

    assign pready           = 1'b1;
    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_out_kind       = r_o_kind;
    assign o_set_x          = r_o_x;
    assign o_set_y          = r_o_y;
    assign o_set_z          = r_o_z;
    assign o_set_yaw        = r_o_yaw;
    assign o_measured_theta = r_o_meas;
    assign o_sender_id      = r_o_id;

    a_started_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |=> r_started)
        else $error("started flag dropped");

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({mul_start, div_start, cor_start}))
        else $error("two arithmetic units launched together");

    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_SPD1 || r_state == S_SPD2 || r_state == S_ADV1 ||
                      r_state == S_ADV2 || r_state == S_RAD))
        else $error("product finished outside a multiply step");

    a_out_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> r_started)
        else $error("result before notification");

endmodule

// ===== tb/circle_formation_setpoint_generator_test.sv =====
module circle_formation_setpoint_generator_test;

    localparam int SETTLE_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        logic [1:0]         kind;
        logic [31:0]        elapsed;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] peer;
        logic               nan;
        logic [7:0]         index;
        logic [7:0]         total;
    } t_cmd;

    typedef struct {
        logic               kind;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [15:0]        yaw;
        logic signed [15:0] meas;
        logic [7:0]         id;
    } t_setpoint;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [1:0] kind = '0;
    logic [31:0] elapsed = '0;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_y = '0;
    logic signed [15:0] peer_theta = '0;
    logic peer_nan = 1'b0;
    logic [7:0] veh_index = '0;
    logic [7:0] veh_total = '0;
    logic out_stall = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;

    logic in_stall, out_valid, out_kind, pready;
    logic signed [31:0] set_x, set_y, set_z;
    logic [15:0] set_yaw;
    logic signed [15:0] meas_theta;
    logic [7:0] sender_id;
    logic [31:0] prdata;

    circle_formation_setpoint_generator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_kind(kind), .i_elapsed_ms(elapsed), .i_pos_x(pos_x), .i_pos_y(pos_y),
        .i_peer_theta(peer_theta), .i_peer_theta_nan(peer_nan),
        .i_vehicle_index(veh_index), .i_vehicle_total(veh_total),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_out_kind(out_kind), .o_set_x(set_x), .o_set_y(set_y), .o_set_z(set_z),
        .o_set_yaw(set_yaw), .o_measured_theta(meas_theta), .o_sender_id(sender_id),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [31:0] radius_r = 32'd65536;
    logic [31:0] altitude_r = 32'd65536;
    logic [31:0] gain_r = 32'd16777;
    logic [7:0]  own_id_r = 8'd0;
    longint      speed_r = 0;
    logic [15:0] start_phase_r = '0;
    logic [15:0] set_phase_r = '0;
    logic        started_r = 1'b0;

    t_setpoint pending_setpoints[$];
    int errors = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    int hold_left = 0;

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [31:0] to_q16(input longint v);
        longint r;
        r = sat32((v + 32768) >>> 16);
        return r[31:0];
    endfunction

    function automatic void circle_point(input logic [15:0] ph, output longint cx,
                                         output longint sy);
        longint x, y, z, dx, dy;
        logic [63:0] pr;
        logic [4:0] k;
        pr = {32'b0, radius_r} * {32'b0, cfsg_pkg::CORDIC_GAIN_Q32};
        x = longint'(pr >> 16);
        y = 0;
        z = longint'({48'b0, ph}) * 65536;
        if (z >= 64'sd2147483648) z -= 64'sd4294967296;
        if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648;
            x = -x;
        end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648;
            x = -x;
        end
        for (int i = 0; i < cfsg_pkg::ITERATIONS; i++) begin
            k = i[4:0];
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'({32'b0, cfsg_pkg::atan_turn(k)});
            end else begin
                x += dx; y -= dy; z += longint'({32'b0, cfsg_pkg::atan_turn(k)});
            end
        end
        cx = x;
        sy = y;
    endfunction

    function automatic logic [15:0] bearing(input logic signed [31:0] px,
                                            input logic signed [31:0] py);
        longint x, y, z, dx, dy, t;
        logic [4:0] k;
        x = longint'(px) * 65536;
        y = longint'(py) * 65536;
        z = 0;
        if (x == 0 && y == 0) return 16'd0;
        if (x < 0) begin
            z = (y >= 0) ? 64'sd2147483648 : -64'sd2147483648;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < cfsg_pkg::ITERATIONS; i++) begin
            k = i[4:0];
            dx = y >>> k;
            dy = x >>> k;
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'({32'b0, cfsg_pkg::atan_turn(k)});
            end else begin
                x -= dx; y += dy; z -= longint'({32'b0, cfsg_pkg::atan_turn(k)});
            end
        end
        t = (z + 32768) >>> 16;
        return t[15:0];
    endfunction

    function automatic logic [15:0] phase_advance(input logic [31:0] el);
        logic [63:0] mag, em;
        logic [127:0] prod, rem, q;
        logic [15:0] adv;
        if (radius_r == 0) return 16'd0;
        mag = (speed_r < 0) ? -speed_r : speed_r;
        em = {32'b0, el} * mag;
        prod = {64'b0, em} * {92'b0, cfsg_pkg::TURN_RATE_Q48};
        rem = (prod >> 32) % ({96'b0, radius_r} << 16);
        q = rem / {96'b0, radius_r};
        adv = q[15:0];
        if (speed_r < 0) adv = 16'd0 - adv;
        return adv;
    endfunction

    function automatic t_setpoint make_setpoint(input logic k, input logic [15:0] m,
                                                input logic [7:0] id);
        t_setpoint s;
        longint cx, sy;
        circle_point(set_phase_r, cx, sy);
        s.kind = k;
        s.x = to_q16(cx);
        s.y = to_q16(sy);
        s.z = altitude_r;
        s.yaw = set_phase_r;
        s.meas = m;
        s.id = id;
        return s;
    endfunction

    function automatic void predict_setpoint(input t_cmd c);
        longint diff, mag;
        logic [63:0] p, a, bb, st;
        logic [23:0] q;
        case (c.kind)
            cfsg_pkg::KIND_NOTE: begin
                if (c.total != 0 && !started_r) begin
                    q = ({c.index, 16'b0}) / {16'b0, c.total};
                    start_phase_r = q[15:0];
                    set_phase_r = start_phase_r;
                    started_r = 1'b1;
                    pending_setpoints.push_back(make_setpoint(cfsg_pkg::OUT_START, 16'd0,
                                                              8'd0));
                end
            end
            cfsg_pkg::KIND_PEER: begin
                if (!c.nan) begin
                    diff = longint'({48'b0, set_phase_r}) - longint'(c.peer);
                    mag = (diff < 0) ? -diff : diff;
                    p = {32'b0, gain_r} * mag;
                    a = (p >> 24) * {32'b0, cfsg_pkg::TWO_PI_Q29};
                    bb = {40'b0, p[23:0]} * {32'b0, cfsg_pkg::TWO_PI_Q29};
                    st = (a + (bb >> 24)) >> 29;
                    if (diff < 0) speed_r = sat32(speed_r - longint'(st));
                    else speed_r = sat32(speed_r + longint'(st));
                end
            end
            cfsg_pkg::KIND_TICK: begin
                if (started_r) begin
                    logic [15:0] m;
                    m = bearing(c.px, c.py);
                    set_phase_r = start_phase_r + phase_advance(c.elapsed);
                    pending_setpoints.push_back(make_setpoint(cfsg_pkg::OUT_TRACK, m,
                                                              own_id_r));
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_cmd(input t_cmd c);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        kind <= c.kind;
        elapsed <= c.elapsed;
        pos_x <= c.px;
        pos_y <= c.py;
        peer_theta <= c.peer;
        peer_nan <= c.nan;
        veh_index <= c.index;
        veh_total <= c.total;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (in_stall);
        predict_setpoint(c);
    endtask

    function automatic t_cmd mk(input logic [1:0] k, input logic [31:0] el,
                                input logic [31:0] x, input logic [31:0] y,
                                input logic [15:0] pt, input logic n,
                                input logic [7:0] idx, input logic [7:0] tot);
        t_cmd c;
        c.kind = k; c.elapsed = el; c.px = x; c.py = y;
        c.peer = pt; c.nan = n; c.index = idx; c.total = tot;
        return c;
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int r;
        r = $urandom_range(0, 99);
        c = mk(cfsg_pkg::KIND_TICK, $urandom, $urandom, $urandom, 16'($urandom),
               1'($urandom), 8'($urandom), 8'($urandom));
        if (r < 35) c.kind = cfsg_pkg::KIND_PEER;
        else if (r < 40) c.kind = cfsg_pkg::KIND_NOTE;
        else if (r < 44) c.kind = cfsg_pkg::KIND_UNUSED;
        c.nan = ($urandom_range(0, 9) == 0);
        if ($urandom_range(0, 2) == 0) c.elapsed = $urandom_range(0, 5000);
        return c;
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_setpoints.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            cfsg_pkg::REG_RADIUS:   radius_r = v;
            cfsg_pkg::REG_ALTITUDE: altitude_r = v;
            cfsg_pkg::REG_INIT_SPD: speed_r = longint'(signed'(v));
            cfsg_pkg::REG_GAIN:     gain_r = v;
            cfsg_pkg::REG_OWN_ID:   own_id_r = v[7:0];
            default: ;
        endcase
    endtask

    task automatic test_before_start();
        send_cmd(mk(cfsg_pkg::KIND_TICK, 32'd1000, 32'h00010000, 32'h00010000, 16'd0, 1'b0,
                    8'd0, 8'd0));
        send_cmd(mk(cfsg_pkg::KIND_PEER, 32'd0, 32'd0, 32'd0, 16'h7FFF, 1'b1, 8'd0, 8'd0));
        send_cmd(mk(cfsg_pkg::KIND_PEER, 32'd0, 32'd0, 32'd0, 16'h8000, 1'b0, 8'd0, 8'd0));
        send_cmd(mk(cfsg_pkg::KIND_NOTE, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0, 8'd3, 8'd0));
        send_cmd(mk(cfsg_pkg::KIND_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                    16'hFFFF, 1'b1, 8'hFF, 8'hFF));
    endtask

    task automatic test_notify();
        send_cmd(mk(cfsg_pkg::KIND_NOTE, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0, 8'd200, 8'd3));
        send_cmd(mk(cfsg_pkg::KIND_NOTE, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0, 8'd1, 8'd255));
        drain();
    endtask

    task automatic test_directed_ticks();
        send_cmd(mk(cfsg_pkg::KIND_PEER, 32'd0, 32'd0, 32'd0, 16'h7FFF, 1'b0, 8'd0, 8'd0));
        send_cmd(mk(cfsg_pkg::KIND_TICK, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0, 8'd0, 8'd0));
        send_cmd(mk(cfsg_pkg::KIND_TICK, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'd0,
                    1'b0, 8'd0, 8'd0));
        send_cmd(mk(cfsg_pkg::KIND_TICK, 32'd20, 32'h80000000, 32'h80000000, 16'd0, 1'b0,
                    8'd0, 8'd0));
        send_cmd(mk(cfsg_pkg::KIND_TICK, 32'd50, 32'h80000000, 32'd0, 16'd0, 1'b0, 8'd0,
                    8'd0));
        send_cmd(mk(cfsg_pkg::KIND_TICK, 32'd70, 32'd0, 32'h80000000, 16'd0, 1'b0, 8'd0,
                    8'd0));
        send_cmd(mk(cfsg_pkg::KIND_TICK, 32'd90, 32'hFFFF0000, 32'h00010000, 16'd0, 1'b0,
                    8'd0, 8'd0));
        send_cmd(mk(cfsg_pkg::KIND_PEER, 32'd0, 32'd0, 32'd0, 16'h8000, 1'b0, 8'd0, 8'd0));
        send_cmd(mk(cfsg_pkg::KIND_TICK, 32'd1234, 32'h00020000, 32'hFFFE0000, 16'd0, 1'b0,
                    8'd0, 8'd0));
        drain();
    endtask

    task automatic test_setting(input logic [31:0] rad, input logic [31:0] alt,
                                input logic [31:0] spd, input logic [31:0] gain,
                                input logic [7:0] id, input int n);
        reg_write(cfsg_pkg::REG_RADIUS, rad);
        reg_write(cfsg_pkg::REG_ALTITUDE, alt);
        reg_write(cfsg_pkg::REG_INIT_SPD, spd);
        reg_write(cfsg_pkg::REG_GAIN, gain);
        reg_write(cfsg_pkg::REG_OWN_ID, {24'b0, id});
        @(posedge i_clk);
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
            send_cmd(random_cmd());
        end
        quiet = 1'b0;
        drain();
    endtask

    always @(posedge i_clk) begin
        int nxt;
        t_setpoint e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_setpoints.size() == 0) begin
                $error("unexpected setpoint transaction");
                errors++;
            end else begin
                e = pending_setpoints.pop_front();
                if (out_kind !== e.kind) begin
                    $error("out_kind exp %0d act %0d", e.kind, out_kind); errors++;
                end
                if (set_x !== e.x) begin
                    $error("set_x exp %0d act %0d", e.x, set_x); errors++;
                end
                if (set_y !== e.y) begin
                    $error("set_y exp %0d act %0d", e.y, set_y); errors++;
                end
                if (set_z !== e.z) begin
                    $error("set_z exp %0d act %0d", e.z, set_z); errors++;
                end
                if (set_yaw !== e.yaw) begin
                    $error("set_yaw exp %0d act %0d", e.yaw, set_yaw); errors++;
                end
                if (meas_theta !== e.meas) begin
                    $error("measured_theta exp %0d act %0d", e.meas, meas_theta);
                    errors++;
                end
                if (sender_id !== e.id) begin
                    $error("sender_id exp %0d act %0d", e.id, sender_id); errors++;
                end
            end
            hold_left = quiet ? 0 : $urandom_range(0, 9);
            out_stall <= (hold_left != 0);
        end else if (hold_left > 0) begin
            nxt = hold_left - 1;
            hold_left = nxt;
            out_stall <= (nxt != 0);
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_before_start();
        test_notify();
        test_directed_ticks();
        test_setting(32'd65536, 32'd65536, 32'h00020000, 32'd16777, 8'd5, 170);
        test_setting(32'd1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd0, 8'd255, 170);
        test_setting(32'hFFFFFFFF, 32'h80000000, 32'h80000000, 32'hFFFFFFFF, 8'd0, 170);
        test_setting(32'd0, 32'd0, 32'd0, 32'h01000000, 8'hAA, 60);
        test_setting($urandom_range(1, 32'h00200000), $urandom, $urandom_range(0, 32'h80000),
                     $urandom_range(0, 32'h00100000), 8'($urandom), 280);
        drain();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/cfsg_pkg.sv
rtl/core/cfsg_mul.sv
rtl/core/cfsg_div.sv
rtl/core/cfsg_cordic.sv
rtl/core/circle_formation_setpoint_generator.sv
tb/circle_formation_setpoint_generator_test.sv
